@@ hw/rtl/drbt_pkg.sv @@
// Shared types and constants for the DRAM row buffer timing unit.
package drbt_pkg;

  localparam int LINE_ADDR_W = 48;
  localparam int DELAY_W     = 8;
  localparam int CNT_W       = 32;
  localparam int SUM_W       = 40;
  localparam int LOG2_W      = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 4;

  localparam logic [DELAY_W-1:0] LAT_FIXED = 8'd100;
  localparam logic [DELAY_W-1:0] LAT_ACT   = 8'd45;
  localparam logic [DELAY_W-1:0] LAT_CAS   = 8'd45;
  localparam logic [DELAY_W-1:0] LAT_PRE   = 8'd45;
  localparam logic [DELAY_W-1:0] LAT_BUS   = 8'd10;

  localparam logic [LOG2_W-1:0] LINE_LOG2_RESET = 4'd6;

  typedef enum logic [1:0] {
    ROW_HIT      = 2'd0,
    ROW_EMPTY    = 2'd1,
    ROW_CONFLICT = 2'd2,
    ROW_NONE     = 2'd3
  } row_outcome_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIXED_LAT  = 2'd0,
    REG_CLOSE_PAGE = 2'd1,
    REG_LINE_LOG2  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic              fixed_latency_mode;
    logic              close_page;
    logic [LOG2_W-1:0] line_bytes_log2;
  } cfg_t;

  // Control from the pipeline to the row buffer table.
  typedef struct packed {
    logic fire;        // item moves into the result register this cycle
    logic fixed_mode;
    logic close_page;
  } bank_req_t;

endpackage

@@ hw/rtl/drbt_req_if.sv @@
// Access request channel.
interface drbt_req_if import drbt_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [LINE_ADDR_W-1:0] line_address;
  logic                   mode;

  modport source (output valid, line_address, mode, input ready);
  modport sink   (input valid, line_address, mode, output ready);
endinterface

@@ hw/rtl/drbt_rsp_if.sv @@
// Access result channel.
interface drbt_rsp_if import drbt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DELAY_W-1:0] delay;
  logic [1:0]         row_outcome;
  logic [CNT_W-1:0]   read_count;
  logic [CNT_W-1:0]   write_count;
  logic [SUM_W-1:0]   read_delay_total;
  logic [SUM_W-1:0]   write_delay_total;

  modport source (output valid, delay, row_outcome, read_count, write_count,
                  read_delay_total, write_delay_total, input ready);
  modport sink   (input valid, delay, row_outcome, read_count, write_count,
                  read_delay_total, write_delay_total, output ready);
endinterface

@@ hw/rtl/drbt_cfg_if.sv @@
// Configuration register write channel.
interface drbt_cfg_if import drbt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/dram_row_buffer_timing_unit.sv @@
// DRAM row buffer timing unit: per-access latency and outcome with running statistics.
//
// Each request transaction on req carries a line address and a mode (0 read,
// 1 write). For every request exactly one result transaction appears on rsp with
// the access delay, the row buffer outcome and the read/write counts and delay
// totals including that access. Registers are written through cfg (index 0
// fixed latency mode, 1 close page, 2 log2 line size); cfg is always ready. The
// user writes cfg only while no request is in flight; the block does not enforce it.
// Throughput is one request per cycle while rsp is not stalled. An input register
// takes the request, and the row buffer lookup, per-bank row update and
// statistics update happen in one pass into the result register.
// The bank count and row size must be powers of two; the bank and row come
// from bit selects and a shift of the address.
// Reset clears all row buffers to closed, zeroes the statistics and returns
// the registers to fixed mode off, open page and 64-byte lines.
// When rsp is stalled the result holds and the input register still takes one
// more request; further requests wait until the result is taken.
module dram_row_buffer_timing_unit import drbt_pkg::*; #(
  parameter int NUM_BANKS = 16,
  parameter int ROW_BYTES = 1024,
  parameter int ADDR_BITS = 48
) (
  input logic        clk,
  input logic        rst,
  drbt_req_if.sink   req,
  drbt_rsp_if.source rsp,
  drbt_cfg_if.sink   cfg
);

  localparam int AW        = (ADDR_BITS < LINE_ADDR_W) ? ADDR_BITS : LINE_ADDR_W;
  localparam int BANK_BITS = $clog2(NUM_BANKS);
  localparam int BANK_W    = (BANK_BITS > 0) ? BANK_BITS : 1;
  localparam int ROW_W     = AW - BANK_BITS;

  cfg_t cfg_reg;

  logic                   s1_valid;
  logic [LINE_ADDR_W-1:0] s1_addr;
  logic                   s1_mode;

  logic               out_valid;
  logic [DELAY_W-1:0] out_delay;
  row_outcome_t       out_outcome;

  logic               advance;
  logic               fire;
  logic [BANK_W-1:0]  bank;
  logic [ROW_W-1:0]   row;
  logic [DELAY_W-1:0] delay;
  row_outcome_t       outcome;
  bank_req_t          bank_req;

  // Configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_reg.fixed_latency_mode <= 1'b0;
      cfg_reg.close_page         <= 1'b0;
      cfg_reg.line_bytes_log2    <= LINE_LOG2_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_FIXED_LAT:  cfg_reg.fixed_latency_mode <= cfg.data[0];
        REG_CLOSE_PAGE: cfg_reg.close_page         <= cfg.data[0];
        REG_LINE_LOG2:  cfg_reg.line_bytes_log2    <= cfg.data[LOG2_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control
  assign advance   = !out_valid || rsp.ready;
  assign fire      = s1_valid && advance;
  assign req.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_addr <= req.line_address;
      s1_mode <= req.mode;
    end
  end

  drbt_decode #(
    .NUM_BANKS (NUM_BANKS),
    .ROW_BYTES (ROW_BYTES),
    .ADDR_BITS (ADDR_BITS)
  ) u_decode (
    .line_address    (s1_addr),
    .line_bytes_log2 (cfg_reg.line_bytes_log2),
    .bank            (bank),
    .row             (row)
  );

  assign bank_req.fire       = fire;
  assign bank_req.fixed_mode = cfg_reg.fixed_latency_mode;
  assign bank_req.close_page = cfg_reg.close_page;

  drbt_bank #(
    .NUM_BANKS (NUM_BANKS),
    .BANK_W    (BANK_W),
    .ROW_W     (ROW_W)
  ) u_bank (
    .clk     (clk),
    .rst     (rst),
    .req     (bank_req),
    .bank    (bank),
    .row     (row),
    .delay   (delay),
    .outcome (outcome)
  );

  // Statistics registers move with the result register, so they are the
  // result's count and total fields.
  drbt_stats u_stats (
    .clk               (clk),
    .rst               (rst),
    .fire              (fire),
    .is_write          (s1_mode),
    .delay             (delay),
    .read_count        (rsp.read_count),
    .write_count       (rsp.write_count),
    .read_delay_total  (rsp.read_delay_total),
    .write_delay_total (rsp.write_delay_total)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_delay   <= delay;
      out_outcome <= outcome;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.delay       = out_delay;
  assign rsp.row_outcome = out_outcome;

  a_result_follows_item: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("item left the input register without a result");

  a_no_result_without_item: assert property (@(posedge clk) disable iff (rst)
    advance && !s1_valid |=> !out_valid)
    else $error("result shown with no item behind it");

endmodule

@@ hw/rtl/drbt_decode.sv @@
// Line address to bank and row decode.
module drbt_decode import drbt_pkg::*; #(
  parameter int NUM_BANKS = 16,
  parameter int ROW_BYTES = 1024,
  parameter int ADDR_BITS = 48,
  localparam int AW        = (ADDR_BITS < LINE_ADDR_W) ? ADDR_BITS : LINE_ADDR_W,
  localparam int BANK_BITS = $clog2(NUM_BANKS),
  localparam int BANK_W    = (BANK_BITS > 0) ? BANK_BITS : 1,
  localparam int ROW_W     = AW - BANK_BITS
) (
  input  logic [LINE_ADDR_W-1:0] line_address,
  input  logic [LOG2_W-1:0]      line_bytes_log2,
  output logic [BANK_W-1:0]      bank,
  output logic [ROW_W-1:0]       row
);

  // NUM_BANKS and ROW_BYTES are powers of two, so both divisions are shifts.
  localparam int ROW_LOG = $clog2(ROW_BYTES);
  localparam int SHIFT_W = $clog2(ROW_LOG + 1);

  logic [AW-1:0]      addr;
  logic [ROW_W-1:0]   row_base;
  logic [SHIFT_W-1:0] line_shift;

  assign addr     = line_address[AW-1:0];
  assign row_base = addr[AW-1:BANK_BITS];

  generate
    if (BANK_BITS > 0) begin : g_bank
      assign bank = addr[BANK_W-1:0];
    end else begin : g_one_bank
      assign bank = '0;
    end
  endgenerate

  // log2 of lines per row; a line larger than a row counts as one line
  always_comb begin
    if (int'(line_bytes_log2) >= ROW_LOG) begin
      line_shift = '0;
    end else begin
      line_shift = SHIFT_W'(ROW_LOG) - SHIFT_W'(line_bytes_log2);
    end
  end

  assign row = row_base >> line_shift;

endmodule

@@ hw/rtl/drbt_bank.sv @@
// Per-bank row buffer table: latency and outcome lookup with row update.
module drbt_bank import drbt_pkg::*; #(
  parameter int NUM_BANKS = 16,
  parameter int BANK_W    = 4,
  parameter int ROW_W     = 44
) (
  input  logic               clk,
  input  logic               rst,
  input  bank_req_t          req,
  input  logic [BANK_W-1:0]  bank,
  input  logic [ROW_W-1:0]   row,
  output logic [DELAY_W-1:0] delay,
  output row_outcome_t       outcome
);

  logic [NUM_BANKS-1:0] bank_open;
  logic [ROW_W-1:0]     bank_row [NUM_BANKS];

  logic open_page;
  logic row_match;
  logic write_row;

  assign open_page = !req.fixed_mode && !req.close_page;
  assign row_match = bank_row[bank] == row;

  always_comb begin
    write_row = 1'b0;
    if (req.fixed_mode) begin
      delay   = LAT_FIXED;
      outcome = ROW_NONE;
    end else if (req.close_page) begin
      delay   = LAT_CAS + LAT_BUS + LAT_ACT;
      outcome = ROW_NONE;
    end else if (!bank_open[bank]) begin
      delay     = LAT_CAS + LAT_BUS + LAT_ACT;
      outcome   = ROW_EMPTY;
      write_row = 1'b1;
    end else if (row_match) begin
      delay   = LAT_CAS + LAT_BUS;
      outcome = ROW_HIT;
    end else begin
      delay     = LAT_CAS + LAT_BUS + LAT_PRE + LAT_ACT;
      outcome   = ROW_CONFLICT;
      write_row = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_open <= '0;
    end else if (req.fire && open_page) begin
      bank_open[bank] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.fire && write_row) begin
      bank_row[bank] <= row;
    end
  end

  a_open_after_access: assert property (@(posedge clk) disable iff (rst)
    req.fire && open_page |=> bank_open[$past(bank)])
    else $error("bank not marked open after an open page access");

  a_bypass_keeps_table: assert property (@(posedge clk) disable iff (rst)
    req.fire && !open_page |=> $stable(bank_open))
    else $error("row buffer state changed in fixed or close page mode");

endmodule

@@ hw/rtl/drbt_stats.sv @@
// Saturating read/write access counts and delay totals.
module drbt_stats import drbt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  logic               is_write,
  input  logic [DELAY_W-1:0] delay,
  output logic [CNT_W-1:0]   read_count,
  output logic [CNT_W-1:0]   write_count,
  output logic [SUM_W-1:0]   read_delay_total,
  output logic [SUM_W-1:0]   write_delay_total
);

  logic [CNT_W-1:0] read_count_next;
  logic [CNT_W-1:0] write_count_next;
  logic [SUM_W-1:0] read_total_next;
  logic [SUM_W-1:0] write_total_next;
  logic [SUM_W:0]   read_sum;
  logic [SUM_W:0]   write_sum;

  assign read_sum  = {1'b0, read_delay_total} + (SUM_W + 1)'(delay);
  assign write_sum = {1'b0, write_delay_total} + (SUM_W + 1)'(delay);

  always_comb begin
    read_count_next  = (&read_count) ? read_count : read_count + CNT_W'(1);
    write_count_next = (&write_count) ? write_count : write_count + CNT_W'(1);
    read_total_next  = read_sum[SUM_W] ? '1 : read_sum[SUM_W-1:0];
    write_total_next = write_sum[SUM_W] ? '1 : write_sum[SUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_count        <= '0;
      write_count       <= '0;
      read_delay_total  <= '0;
      write_delay_total <= '0;
    end else if (fire) begin
      if (is_write) begin
        write_count       <= write_count_next;
        write_delay_total <= write_total_next;
      end else begin
        read_count       <= read_count_next;
        read_delay_total <= read_total_next;
      end
    end
  end

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(read_count) && $stable(write_count) &&
              $stable(read_delay_total) && $stable(write_delay_total))
    else $error("statistics changed without a transaction");

  a_write_leaves_reads: assert property (@(posedge clk) disable iff (rst)
    fire && is_write |=> $stable(read_count) && $stable(read_delay_total))
    else $error("write transaction touched read statistics");

endmodule
